/* hdl/assert_macros.svh */
// Assertion macros shared by the pixel hit event detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/phed_pkg.sv */
// Shared constants and types of the pixel hit event detector.
package phed_pkg;

    localparam int LUMA_W           = 8;
    localparam int COL_W            = 10;
    localparam int ROW_W            = 9;
    localparam int CODE_W           = 8;
    localparam int CODE_SCALE       = 256;
    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [LUMA_W-1:0] LIT_THRESHOLD_RST = 8'd4;
    localparam logic              EVENT_MODE_RST    = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIT_THRESHOLD = 1'b0,
        REG_EVENT_MODE    = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_EVENT = 1'b0,
        KIND_FRAME = 1'b1
    } kind_t;

endpackage

/* hdl/phed_if.sv */
// Pixel and result channel interfaces of the pixel hit event detector.
interface phed_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [phed_pkg::LUMA_W-1:0]   luma;
    logic                          last_of_frame;

    modport source (output valid, output luma, output last_of_frame, input ready);
    modport sink   (input valid, input luma, input last_of_frame, output ready);
endinterface

interface phed_result_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [phed_pkg::COL_W-1:0]    column;
    logic [phed_pkg::ROW_W-1:0]    row;
    logic [phed_pkg::CODE_W-1:0]   column_code;
    logic [phed_pkg::CODE_W-1:0]   row_code;

    modport source (output valid, output kind, output column, output row,
                    output column_code, output row_code, input ready);
    modport sink   (input valid, input kind, input column, input row,
                    input column_code, input row_code, output ready);
endinterface

/* hdl/phed_ram.sv */
// Generic RAM: one write port, two registered read ports, read-before-write.
module phed_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = phed_pkg::FRAME_WIDTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem_reg[rd_addr_a];
            rd_data_b <= mem_reg[rd_addr_b];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

endmodule

/* hdl/phed_pos.sv */
// Raster position counters with incremental 8-bit column and row codes.
module phed_pos #(
    parameter int FRAME_WIDTH  = phed_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = phed_pkg::FRAME_HEIGHT_DEF,
    localparam int COL_CW = $clog2(FRAME_WIDTH),
    localparam int ROW_CW = $clog2(FRAME_HEIGHT)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        last_of_frame,
    output logic [COL_CW-1:0]           col,
    output logic [ROW_CW-1:0]           row,
    output logic [phed_pkg::CODE_W-1:0] col_code,
    output logic [phed_pkg::CODE_W-1:0] row_code,
    output logic                        col_last
);

    localparam int CODE_W    = phed_pkg::CODE_W;
    localparam int COL_SW    = COL_CW + 1;
    localparam int ROW_SW    = ROW_CW + 1;
    localparam int COL_QSTEP = phed_pkg::CODE_SCALE / FRAME_WIDTH;
    localparam int COL_RSTEP = phed_pkg::CODE_SCALE % FRAME_WIDTH;
    localparam int ROW_QSTEP = phed_pkg::CODE_SCALE / FRAME_HEIGHT;
    localparam int ROW_RSTEP = phed_pkg::CODE_SCALE % FRAME_HEIGHT;

    localparam logic [COL_CW-1:0] COL_MAX     = COL_CW'(FRAME_WIDTH - 1);
    localparam logic [ROW_CW-1:0] ROW_MAX     = ROW_CW'(FRAME_HEIGHT - 1);
    localparam logic [COL_SW-1:0] COL_MOD_V   = COL_SW'(FRAME_WIDTH);
    localparam logic [ROW_SW-1:0] ROW_MOD_V   = ROW_SW'(FRAME_HEIGHT);
    localparam logic [COL_SW-1:0] COL_RSTEP_V = COL_SW'(COL_RSTEP);
    localparam logic [ROW_SW-1:0] ROW_RSTEP_V = ROW_SW'(ROW_RSTEP);
    localparam logic [CODE_W-1:0] COL_QSTEP_V = CODE_W'(COL_QSTEP);
    localparam logic [CODE_W-1:0] ROW_QSTEP_V = CODE_W'(ROW_QSTEP);

    logic [COL_CW-1:0] col_reg, col_next;
    logic [ROW_CW-1:0] row_reg, row_next;
    logic [COL_CW-1:0] col_rem_reg, col_rem_next;
    logic [ROW_CW-1:0] row_rem_reg, row_rem_next;
    logic [CODE_W-1:0] col_code_reg, col_code_next;
    logic [CODE_W-1:0] row_code_reg, row_code_next;

    logic [COL_SW-1:0] col_sum;
    logic [ROW_SW-1:0] row_sum;
    logic              col_carry, row_carry;
    logic [COL_CW-1:0] col_rem_step;
    logic [ROW_CW-1:0] row_rem_step;
    logic [CODE_W-1:0] col_code_step, row_code_step;
    logic              row_last;

    // code = floor(pos * 256 / size), kept as quotient plus remainder
    assign col_sum       = {1'b0, col_rem_reg} + COL_RSTEP_V;
    assign col_carry     = (col_sum >= COL_MOD_V);
    assign col_rem_step  = col_carry ? COL_CW'(col_sum - COL_MOD_V) : COL_CW'(col_sum);
    assign col_code_step = col_code_reg + COL_QSTEP_V + CODE_W'(col_carry);

    assign row_sum       = {1'b0, row_rem_reg} + ROW_RSTEP_V;
    assign row_carry     = (row_sum >= ROW_MOD_V);
    assign row_rem_step  = row_carry ? ROW_CW'(row_sum - ROW_MOD_V) : ROW_CW'(row_sum);
    assign row_code_step = row_code_reg + ROW_QSTEP_V + CODE_W'(row_carry);

    assign col_last = (col_reg == COL_MAX);
    assign row_last = (row_reg == ROW_MAX);

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        col_rem_next  = col_rem_reg;
        row_rem_next  = row_rem_reg;
        col_code_next = col_code_reg;
        row_code_next = row_code_reg;
        if (advance)
        begin
            if (last_of_frame)
            begin
                col_next      = '0;
                row_next      = '0;
                col_rem_next  = '0;
                row_rem_next  = '0;
                col_code_next = '0;
                row_code_next = '0;
            end
            else if (col_last)
            begin
                col_next      = '0;
                col_rem_next  = '0;
                col_code_next = '0;
                // saturate on the last row when the frame end is missing
                if (!row_last)
                begin
                    row_next      = row_reg + ROW_CW'(1);
                    row_rem_next  = row_rem_step;
                    row_code_next = row_code_step;
                end
            end
            else
            begin
                col_next      = col_reg + COL_CW'(1);
                col_rem_next  = col_rem_step;
                col_code_next = col_code_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            col_rem_reg  <= '0;
            row_rem_reg  <= '0;
            col_code_reg <= '0;
            row_code_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            col_rem_reg  <= col_rem_next;
            row_rem_reg  <= row_rem_next;
            col_code_reg <= col_code_next;
            row_code_reg <= row_code_next;
        end
    end

    assign col      = col_reg;
    assign row      = row_reg;
    assign col_code = col_code_reg;
    assign row_code = row_code_reg;

endmodule

/* hdl/pixel_hit_event_detector.sv */
// Top level of the pixel hit event detector: line store, neighbor test, result register.
//
//  channel | direction | transaction carries
//  --------+-----------+-------------------------------------------------------
//  pix     | in        | luma, last_of_frame
//  res     | out       | kind, column, row, column_code, row_code
//  cfg     | in        | cfg_wr_en, cfg_index, cfg_wr_data (write only)
//
//  One pixel is accepted per clock while pix.ready is high. Its result, if any, is
//  loaded into the result register from the neighbor stage when that register is free.
//  The line store is a two-read, one-write RAM read at column and column+1 on
//  the accepting edge, so the neighbor stage is the only stop between RAM and result.
//  A stalled result holds the neighbor stage; pix.ready drops only when that
//  stage holds an item that must still emit and the result register is full
//  and not being taken.
//  Reset clears counters, the frame-hit and west flags and pipeline valids; the threshold
//  returns to 4 and the mode to any-hit. The line store is not cleared.
`include "assert_macros.svh"

module pixel_hit_event_detector #(
    parameter int FRAME_WIDTH  = phed_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = phed_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    phed_pixel_if.sink                      pix,
    phed_result_if.source                   res,
    input  logic                            cfg_wr_en,
    input  logic [phed_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phed_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int COL_CW = $clog2(FRAME_WIDTH);
    localparam int ROW_CW = $clog2(FRAME_HEIGHT);
    localparam int COL_W  = phed_pkg::COL_W;
    localparam int ROW_W  = phed_pkg::ROW_W;
    localparam int CODE_W = phed_pkg::CODE_W;
    localparam int LUMA_W = phed_pkg::LUMA_W;

    // neighbor-stage flags for one pixel
    typedef struct packed {
        logic lit;
        logic mode;
        logic frame_hit;
        logic west;
        logic has_n;
        logic has_nw;
        logic has_ne;
    } nbr_flags_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [LUMA_W-1:0] thr_reg, thr_next;
    logic              mode_reg, mode_next;

    always_comb
    begin
        thr_next  = thr_reg;
        mode_next = mode_reg;
        if (cfg_wr_en)
        begin
            case (phed_pkg::cfg_reg_t'(cfg_index))
                phed_pkg::REG_LIT_THRESHOLD: thr_next  = cfg_wr_data[LUMA_W-1:0];
                phed_pkg::REG_EVENT_MODE:    mode_next = cfg_wr_data[0];
                default:                     thr_next  = thr_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input side: position, lit test, frame hit tracking
    // ---------------------------------------------------------------
    logic              pix_acc;
    logic              lit;
    logic [COL_CW-1:0] col;
    logic [ROW_CW-1:0] row;
    logic [CODE_W-1:0] col_code, row_code;
    logic              col_last;
    logic [COL_CW-1:0] ne_addr;

    logic              seen_reg, seen_next;
    logic              left_reg, left_next;
    nbr_flags_t        in_flags;

    assign pix_acc = pix.valid && pix.ready;
    assign lit     = (pix.luma > thr_reg);

    phed_pos #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_pos (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (pix_acc),
        .last_of_frame (pix.last_of_frame),
        .col           (col),
        .row           (row),
        .col_code      (col_code),
        .row_code      (row_code),
        .col_last      (col_last)
    );

    // clear the hit flag at frame end; west neighbor is simply the last lit bit,
    // masked on column zero below
    assign seen_next = pix_acc ? (!pix.last_of_frame && (seen_reg || lit)) : seen_reg;
    assign left_next = pix_acc ? lit : left_reg;

    always_comb
    begin
        in_flags.lit       = lit;
        in_flags.mode      = mode_reg;
        in_flags.frame_hit = !mode_reg && pix.last_of_frame && (seen_reg || lit);
        in_flags.west      = (col != '0) && left_reg;
        in_flags.has_n     = (row != '0);
        in_flags.has_nw    = (row != '0) && (col != '0);
        in_flags.has_ne    = (row != '0) && !col_last;
    end

    // the last column has no east neighbor; any in-range address will do
    assign ne_addr = col_last ? col : col + COL_CW'(1);

    // ---------------------------------------------------------------
    // Line store: lit bits of the row above
    // ---------------------------------------------------------------
    logic north_lit, ne_lit;

    phed_ram #(
        .WIDTH (1),
        .DEPTH (FRAME_WIDTH)
    ) u_line (
        .clk       (clk),
        .wr_en     (pix_acc),
        .wr_addr   (col),
        .wr_data   (lit),
        .rd_en     (pix_acc),
        .rd_addr_a (col),
        .rd_addr_b (ne_addr),
        .rd_data_a (north_lit),
        .rd_data_b (ne_lit)
    );

    // ---------------------------------------------------------------
    // Neighbor stage
    // ---------------------------------------------------------------
    logic              s1_valid_reg, s1_valid_next;
    nbr_flags_t        s1_flags_reg;
    logic [COL_CW-1:0] s1_col_reg;
    logic [ROW_CW-1:0] s1_row_reg;
    logic [CODE_W-1:0] s1_ccode_reg, s1_rcode_reg;
    logic              ul_reg;

    logic              s1_event;
    logic              s1_emit;
    logic              s1_adv;
    logic              out_free;

    // north-west is the north bit of the previous pixel, kept in ul_reg
    assign s1_event = s1_flags_reg.mode && s1_flags_reg.lit
                      && !(s1_flags_reg.has_n && north_lit)
                      && !(s1_flags_reg.has_nw && ul_reg)
                      && !(s1_flags_reg.has_ne && ne_lit)
                      && !s1_flags_reg.west;
    assign s1_emit  = s1_flags_reg.mode ? s1_event : s1_flags_reg.frame_hit;

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                  res_valid_reg, res_valid_next;
    phed_pkg::kind_t       res_kind_reg;
    logic [COL_W-1:0]      res_col_reg;
    logic [ROW_W-1:0]      res_row_reg;
    logic [CODE_W-1:0]     res_ccode_reg, res_rcode_reg;
    logic                  res_load;

    assign out_free  = !res_valid_reg || res.ready;
    assign s1_adv    = s1_valid_reg && (!s1_emit || out_free);
    assign res_load  = s1_adv && s1_emit;
    assign pix.ready = !s1_valid_reg || s1_adv;

    assign s1_valid_next  = pix_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign res_valid_next = res_load ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= phed_pkg::LIT_THRESHOLD_RST;
            mode_reg      <= phed_pkg::EVENT_MODE_RST;
            seen_reg      <= 1'b0;
            left_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            mode_reg      <= mode_next;
            seen_reg      <= seen_next;
            left_reg      <= left_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload: advance the neighbor stage on accept, load the result on emit
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_flags_reg <= in_flags;
            s1_col_reg   <= col;
            s1_row_reg   <= row;
            s1_ccode_reg <= col_code;
            s1_rcode_reg <= row_code;
            ul_reg       <= north_lit;
        end
        if (res_load)
        begin
            if (s1_flags_reg.mode)
            begin
                res_kind_reg  <= phed_pkg::KIND_EVENT;
                res_col_reg   <= COL_W'(s1_col_reg);
                res_row_reg   <= ROW_W'(s1_row_reg);
                res_ccode_reg <= s1_ccode_reg;
                res_rcode_reg <= s1_rcode_reg;
            end
            else
            begin
                res_kind_reg  <= phed_pkg::KIND_FRAME;
                res_col_reg   <= '0;
                res_row_reg   <= '0;
                res_ccode_reg <= '0;
                res_rcode_reg <= '0;
            end
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.kind        = res_kind_reg;
    assign res.column      = res_col_reg;
    assign res.row         = res_row_reg;
    assign res.column_code = res_ccode_reg;
    assign res.row_code    = res_rcode_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic pix_last_acc;
    logic pos_at_origin;

    assign pix_last_acc  = pix_acc && pix.last_of_frame;
    assign pos_at_origin = (col == '0) && (row == '0) && (col_code == '0) && (row_code == '0);

    // a held neighbor stage must block input, or its RAM data would be lost
    `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst_n, s1_valid_reg && !s1_adv, !pix.ready)
    // frame end restarts position and codes
    `ASSERT_NEXT(a_frame_end_restarts, clk, rst_n, pix_last_acc, pos_at_origin)
    // an accepted pixel always lands in the neighbor stage
    `ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, pix_acc, s1_valid_reg)

endmodule
